// File: hdl/lav_pkg.sv
// Shared types and constants for the look-at view matrix unit.
package lav_pkg;

  localparam int FIELD_BITS = 32;
  // Normalizer scales the largest magnitude into [2^SCALE_TOP, 2^(SCALE_TOP+1)).
  localparam int SCALE_TOP  = 29;
  localparam int MAG_BITS   = 30;
  // One integer square root result bit per pipeline step.
  localparam int SQRT_STEPS = 31;
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] upvec_x;
    logic signed [31:0] upvec_y;
    logic signed [31:0] upvec_z;
  } in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] elem_0;
    logic signed [31:0] elem_1;
    logic signed [31:0] elem_2;
    logic signed [31:0] elem_3;
    logic               last_row;
    logic               degenerate;
  } out_t;

  // Per-stage control: slot holds an item, and no zero-length vector seen so far.
  typedef struct packed {
    logic valid;
    logic ok;
  } ctl_t;

endpackage

// File: hdl/lav_norm.sv
// Pipelined 3-vector normalizer: scale, sum of squares, bit-serial sqrt, divide.
module lav_norm #(
  parameter int FRAC_BITS = 16,
  parameter int CW        = 33,
  parameter int SW        = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  lav_pkg::ctl_t            ctl_i,
  input  logic signed [CW-1:0]     comp_i [3],
  input  logic [SW-1:0]            side_i,
  output lav_pkg::ctl_t            ctl_o,
  output logic signed [FRAC_BITS+1:0] unit_o [3],
  output logic [SW-1:0]            side_o
);

  localparam int MW  = lav_pkg::MAG_BITS;
  localparam int TOP = lav_pkg::SCALE_TOP;
  localparam int PW  = $clog2(CW);
  localparam int TW  = CW + MW;
  localparam int NSQ = lav_pkg::SQRT_STEPS;
  localparam int RW  = 2 * NSQ + 1;
  localparam int DW  = NSQ + 2;
  localparam int QW  = FRAC_BITS + 1;
  localparam int UW  = FRAC_BITS + 2;

  // stage 1: magnitudes and signs
  lav_pkg::ctl_t ctl1_q;
  logic [CW-1:0] mag1_q [3];
  logic [2:0]    neg1_q;
  logic [SW-1:0] side1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctl1_q <= '0;
    else if (en_i) ctl1_q <= ctl_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= comp_i[i][CW-1];
        mag1_q[i] <= comp_i[i][CW-1] ? CW'(-comp_i[i]) : CW'(comp_i[i]);
      end
      side1_q <= side_i;
    end
  end

  // stage 2: leading one of the largest magnitude
  logic [CW-1:0] orv;
  logic [PW-1:0] lead_d;
  always_comb begin
    orv    = mag1_q[0] | mag1_q[1] | mag1_q[2];
    lead_d = '0;
    for (int k = 0; k < CW; k++) begin
      if (orv[k]) lead_d = PW'(k);
    end
  end

  lav_pkg::ctl_t ctl2_q;
  logic [PW-1:0] lead2_q;
  logic [CW-1:0] mag2_q [3];
  logic [2:0]    neg2_q;
  logic [SW-1:0] side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctl2_q <= '0;
    else if (en_i) begin
      ctl2_q.valid <= ctl1_q.valid;
      ctl2_q.ok    <= ctl1_q.ok & (|orv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lead2_q <= lead_d;
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      side2_q <= side1_q;
    end
  end

  // stage 3: common shift into the scale window (right shifts truncate)
  logic [TW-1:0] ext [3];
  logic [TW-1:0] shv [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = TW'(mag2_q[i]);
      if (lead2_q >= PW'(TOP)) shv[i] = ext[i] >> (lead2_q - PW'(TOP));
      else                     shv[i] = ext[i] << (PW'(TOP) - lead2_q);
    end
  end

  lav_pkg::ctl_t ctl3_q;
  logic [MW-1:0] mag3_q [3];
  logic [2:0]    neg3_q;
  logic [SW-1:0] side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctl3_q <= '0;
    else if (en_i) ctl3_q <= ctl2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) mag3_q[i] <= shv[i][MW-1:0];
      neg3_q  <= neg2_q;
      side3_q <= side2_q;
    end
  end

  // stage 4: squares
  lav_pkg::ctl_t   ctl4_q;
  logic [2*MW-1:0] sq4_q [3];
  logic [MW-1:0]   mag4_q [3];
  logic [2:0]      neg4_q;
  logic [SW-1:0]   side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctl4_q <= '0;
    else if (en_i) ctl4_q <= ctl3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sq4_q[i] <= (2*MW)'(mag3_q[i]) * (2*MW)'(mag3_q[i]);
      mag4_q  <= mag3_q;
      neg4_q  <= neg3_q;
      side4_q <= side3_q;
    end
  end

  // stage 5: sum of squares
  lav_pkg::ctl_t ctl5_q;
  logic [RW-1:0] s5_q;
  logic [MW-1:0] mag5_q [3];
  logic [2:0]    neg5_q;
  logic [SW-1:0] side5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctl5_q <= '0;
    else if (en_i) ctl5_q <= ctl4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_q    <= RW'(sq4_q[0]) + RW'(sq4_q[1]) + RW'(sq4_q[2]);
      mag5_q  <= mag4_q;
      neg5_q  <= neg4_q;
      side5_q <= side4_q;
    end
  end

  // square root: one result bit per step
  lav_pkg::ctl_t sctl_q  [NSQ];
  logic [RW-1:0] sx_q    [NSQ];
  logic [RW-1:0] sr_q    [NSQ];
  logic [MW-1:0] smag_q  [NSQ][3];
  logic [2:0]    sneg_q  [NSQ];
  logic [SW-1:0] sside_q [NSQ];

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NSQ - 1 - k));
    lav_pkg::ctl_t ctl_s;
    logic [RW-1:0] x_s, r_s, x_n, r_n, trial;
    logic [MW-1:0] mag_s [3];
    logic [2:0]    neg_s;
    logic [SW-1:0] side_s;

    if (k == 0) begin : g_src
      assign ctl_s  = ctl5_q;
      assign x_s    = s5_q;
      assign r_s    = '0;
      assign mag_s  = mag5_q;
      assign neg_s  = neg5_q;
      assign side_s = side5_q;
    end else begin : g_src
      assign ctl_s  = sctl_q[k-1];
      assign x_s    = sx_q[k-1];
      assign r_s    = sr_q[k-1];
      assign mag_s  = smag_q[k-1];
      assign neg_s  = sneg_q[k-1];
      assign side_s = sside_q[k-1];
    end

    always_comb begin
      trial = r_s + BIT;
      if (x_s >= trial) begin
        x_n = x_s - trial;
        r_n = (r_s >> 1) + BIT;
      end else begin
        x_n = x_s;
        r_n = r_s >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sctl_q[k] <= '0;
      else if (en_i) sctl_q[k] <= ctl_s;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sx_q[k]    <= x_n;
        sr_q[k]    <= r_n;
        smag_q[k]  <= mag_s;
        sneg_q[k]  <= neg_s;
        sside_q[k] <= side_s;
      end
    end
  end

  // restoring divide, three lanes, one quotient bit per step
  lav_pkg::ctl_t dctl_q  [QW];
  logic [DW-1:0] drem_q  [QW][3];
  logic [QW-1:0] dquo_q  [QW][3];
  logic [DW-1:0] dlen_q  [QW];
  logic [2:0]    dneg_q  [QW];
  logic [SW-1:0] dside_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    lav_pkg::ctl_t ctl_s;
    logic [DW-1:0] rem_s [3];
    logic [QW-1:0] quo_s [3];
    logic [DW-1:0] len_s;
    logic [2:0]    neg_s;
    logic [SW-1:0] side_s;
    logic [DW-1:0] trial [3];
    logic [DW-1:0] rem_n [3];
    logic [QW-1:0] quo_n [3];

    if (j == 0) begin : g_src
      assign ctl_s  = sctl_q[NSQ-1];
      assign len_s  = sr_q[NSQ-1][DW-1:0];
      assign neg_s  = sneg_q[NSQ-1];
      assign side_s = sside_q[NSQ-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_s[i] = DW'(smag_q[NSQ-1][i]);
        assign quo_s[i] = '0;
      end
    end else begin : g_src
      assign ctl_s  = dctl_q[j-1];
      assign len_s  = dlen_q[j-1];
      assign neg_s  = dneg_q[j-1];
      assign side_s = dside_q[j-1];
      assign rem_s  = drem_q[j-1];
      assign quo_s  = dquo_q[j-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = (j == 0) ? rem_s[i] : (rem_s[i] << 1);
        if (trial[i] >= len_s) begin
          rem_n[i] = trial[i] - len_s;
          quo_n[i] = {quo_s[i][QW-2:0], 1'b1};
        end else begin
          rem_n[i] = trial[i];
          quo_n[i] = {quo_s[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dctl_q[j] <= '0;
      else if (en_i) dctl_q[j] <= ctl_s;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[j]  <= rem_n;
        dquo_q[j]  <= quo_n;
        dlen_q[j]  <= len_s;
        dneg_q[j]  <= neg_s;
        dside_q[j] <= side_s;
      end
    end
  end

  // sign restore
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctl_o <= '0;
    else if (en_i) ctl_o <= dctl_q[QW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        unit_o[i] <= dneg_q[QW-1][i] ? $signed(-UW'(dquo_q[QW-1][i]))
                                     : $signed(UW'(dquo_q[QW-1][i]));
      end
      side_o <= dside_q[QW-1];
    end
  end

endmodule

// File: hdl/lav_cross.sv
// Two-stage full-precision cross product a x b.
module lav_cross #(
  parameter int AW = 32,
  parameter int BW = 18,
  parameter int SW = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  lav_pkg::ctl_t         ctl_i,
  input  logic signed [AW-1:0]  a_i [3],
  input  logic signed [BW-1:0]  b_i [3],
  input  logic [SW-1:0]         side_i,
  output lav_pkg::ctl_t         ctl_o,
  output logic signed [AW+BW-1:0] c_o [3],
  output logic [SW-1:0]         side_o
);

  localparam int PW = AW + BW;

  lav_pkg::ctl_t       ctl1_q;
  logic signed [PW-1:0] prod_q [6];
  logic [SW-1:0]       side1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl_o  <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl_o  <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q[0] <= PW'(a_i[1]) * PW'(b_i[2]);
      prod_q[1] <= PW'(a_i[2]) * PW'(b_i[1]);
      prod_q[2] <= PW'(a_i[2]) * PW'(b_i[0]);
      prod_q[3] <= PW'(a_i[0]) * PW'(b_i[2]);
      prod_q[4] <= PW'(a_i[0]) * PW'(b_i[1]);
      prod_q[5] <= PW'(a_i[1]) * PW'(b_i[0]);
      side1_q   <= side_i;
      c_o[0]    <= prod_q[0] - prod_q[1];
      c_o[1]    <= prod_q[2] - prod_q[3];
      c_o[2]    <= prod_q[4] - prod_q[5];
      side_o    <= side1_q;
    end
  end

endmodule

// File: hdl/lav_out.sv
// Translation terms, saturation and the four-row output register.
module lav_out #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lav_pkg::ctl_t              ctl_i,
  input  logic signed [31:0]         eye_i [3],
  input  logic signed [FRAC_BITS+1:0] u_i [3],
  input  logic signed [FRAC_BITS+1:0] v_i [3],
  input  logic signed [FRAC_BITS+1:0] n_i [3],
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lav_pkg::out_t              out_data_o,
  output logic                       en_o
);

  localparam int UW  = FRAC_BITS + 2;
  localparam int PRW = UW + 32;
  localparam int SMW = PRW + 2;
  localparam int XW  = 72;
  localparam logic signed [XW-1:0] ONE  = XW'(1) << FRAC_BITS;
  localparam logic signed [SMW:0]  HALF = (SMW+1)'(1) << (FRAC_BITS - 1);

  function automatic logic [31:0] sat_fld(input logic signed [XW-1:0] val);
    logic signed [XW-1:0] hi, lo, res;
    hi = (XW'(1) << (WORD_BITS - 1)) - XW'(1);
    lo = -hi - XW'(1);
    if (val > hi)      res = hi;
    else if (val < lo) res = lo;
    else               res = val;
    return res[31:0];
  endfunction

  // stage A: products against the eye point
  logic signed [UW-1:0] unit_s [3][3];
  always_comb begin
    unit_s[0] = u_i;
    unit_s[1] = v_i;
    unit_s[2] = n_i;
  end

  lav_pkg::ctl_t        ctla_q;
  logic signed [PRW-1:0] pr_q [3][3];
  logic signed [UW-1:0] unita_q [3][3];

  // stage B: -(a.eye) rounded to FRAC_BITS, ties up
  logic signed [SMW-1:0] dot_s [3];
  logic signed [SMW:0]   rnd_s [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dot_s[r] = SMW'(pr_q[r][0]) + SMW'(pr_q[r][1]) + SMW'(pr_q[r][2]);
      rnd_s[r] = -(SMW+1)'(dot_s[r]) + HALF;
    end
  end

  lav_pkg::ctl_t        ctlb_q;
  logic signed [SMW:0]  tr_q [3];
  logic signed [UW-1:0] unitb_q [3][3];

  // output register: rows 0..2 kept, row 3 is constant
  logic        busy_q;
  logic [1:0]  row_q;
  logic [31:0] mat_q [3][4];
  logic [31:0] mat_d [3][4];
  logic        deg_q;

  assign en_o = !busy_q || (out_ready_i && (row_q == lav_pkg::ROW_LAST));

  // degenerate items fall back to the identity rows
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 3; i++) begin
        mat_d[r][i] = sat_fld(ctlb_q.ok ? XW'(unitb_q[r][i]) : ((r == i) ? ONE : '0));
      end
      mat_d[r][3] = sat_fld(ctlb_q.ok ? XW'(tr_q[r]) : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctla_q <= '0;
      ctlb_q <= '0;
      busy_q <= 1'b0;
      row_q  <= '0;
    end else if (en_o) begin
      ctla_q <= ctl_i;
      ctlb_q <= ctla_q;
      busy_q <= ctlb_q.valid;
      row_q  <= '0;
    end else if (out_ready_i) begin
      row_q <= row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) pr_q[r][i] <= PRW'(unit_s[r][i]) * PRW'(eye_i[i]);
        tr_q[r] <= rnd_s[r] >>> FRAC_BITS;
      end
      unita_q <= unit_s;
      unitb_q <= unita_q;
      mat_q   <= mat_d;
      deg_q   <= !ctlb_q.ok;
    end
  end

  always_comb begin
    out_valid_o           = busy_q;
    out_data_o.row_index  = row_q;
    out_data_o.last_row   = (row_q == lav_pkg::ROW_LAST);
    out_data_o.degenerate = deg_q;
    if (row_q == lav_pkg::ROW_LAST) begin
      out_data_o.elem_0 = '0;
      out_data_o.elem_1 = '0;
      out_data_o.elem_2 = '0;
      out_data_o.elem_3 = $signed(sat_fld(ONE));
    end else begin
      out_data_o.elem_0 = $signed(mat_q[row_q][0]);
      out_data_o.elem_1 = $signed(mat_q[row_q][1]);
      out_data_o.elem_2 = $signed(mat_q[row_q][2]);
      out_data_o.elem_3 = $signed(mat_q[row_q][3]);
    end
  end

  a_row_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !en_o && out_ready_i |=> row_q == $past(row_q) + 2'd1)
    else $error("row counter skipped");

  a_idle_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> en_o)
    else $error("pipeline stalled with empty output");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctlb_q.valid && !en_o |=> ctlb_q.valid)
    else $error("stalled item dropped");

  a_deg_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && deg_q && (row_q != lav_pkg::ROW_LAST) |-> out_data_o.elem_3 == '0)
    else $error("degenerate row carries translation");

endmodule

// File: hdl/look_at_view_matrix_unit.sv
// Look-at view matrix unit: top level with input register and datapath chain.
// One matrix row per output transfer.
// Each normalizer runs a 31-step sqrt and a FRAC_BITS+1 step divide; all fully pipelined.
// The pipeline stalls as a whole only while the 4-row output register is occupied.
// Reset (rst_ni low, async) clears all valid bits; payload registers are not reset.
module look_at_view_matrix_unit #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lav_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lav_pkg::out_t  out_data_o
);

  localparam int UW  = FRAC_BITS + 2;
  localparam int EW  = 96;            // eye point, packed
  localparam int SWN = EW + 96;       // eye + up
  localparam int SWU = EW + 3 * UW;   // eye + n
  localparam int SWV = EW + 6 * UW;   // eye + n + u

  // Global advance: every stage moves when the output register can take an item.
  logic en;
  assign in_ready_o = en;

  // Input register: view direction eye - target at full 33-bit width.
  lav_pkg::ctl_t      ctl0_q;
  logic signed [32:0] dir0_q [3];
  logic signed [31:0] eye0_q [3];
  logic signed [31:0] up0_q  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctl0_q <= '0;
    else if (en) begin
      ctl0_q.valid <= in_valid_i;
      ctl0_q.ok    <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      eye0_q[0] <= in_data_i.eye_x;
      eye0_q[1] <= in_data_i.eye_y;
      eye0_q[2] <= in_data_i.eye_z;
      up0_q[0]  <= in_data_i.upvec_x;
      up0_q[1]  <= in_data_i.upvec_y;
      up0_q[2]  <= in_data_i.upvec_z;
      dir0_q[0] <= 33'(in_data_i.eye_x) - 33'(in_data_i.target_x);
      dir0_q[1] <= 33'(in_data_i.eye_y) - 33'(in_data_i.target_y);
      dir0_q[2] <= 33'(in_data_i.eye_z) - 33'(in_data_i.target_z);
    end
  end

  // n = normalize(eye - target); eye and up ride along.
  logic [SWN-1:0]       side0;
  lav_pkg::ctl_t        ctl_n;
  logic signed [UW-1:0] n_w [3];
  logic [SWN-1:0]       side_n;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side0[SWN-1-32*i -: 32] = eye0_q[i];
      side0[95-32*i -: 32]    = up0_q[i];
    end
  end

  lav_norm #(.FRAC_BITS(FRAC_BITS), .CW(33), .SW(SWN)) u_norm_n (
    .clk_i, .rst_ni, .en_i(en),
    .ctl_i(ctl0_q), .comp_i(dir0_q), .side_i(side0),
    .ctl_o(ctl_n), .unit_o(n_w), .side_o(side_n)
  );

  // up x n
  logic signed [31:0]    up_n [3];
  logic [SWU-1:0]        side_c1;
  lav_pkg::ctl_t         ctl_c1;
  logic signed [31+UW:0] c1_w [3];
  logic [SWU-1:0]        side_c1o;

  always_comb begin
    side_c1[SWU-1 -: EW] = side_n[SWN-1 -: EW];
    for (int i = 0; i < 3; i++) begin
      up_n[i] = $signed(side_n[95-32*i -: 32]);
      side_c1[3*UW-1-UW*i -: UW] = n_w[i];
    end
  end

  lav_cross #(.AW(32), .BW(UW), .SW(SWU)) u_cross_u (
    .clk_i, .rst_ni, .en_i(en),
    .ctl_i(ctl_n), .a_i(up_n), .b_i(n_w), .side_i(side_c1),
    .ctl_o(ctl_c1), .c_o(c1_w), .side_o(side_c1o)
  );

  // u = normalize(up x n)
  lav_pkg::ctl_t        ctl_u;
  logic signed [UW-1:0] u_w [3];
  logic [SWU-1:0]       side_u;

  lav_norm #(.FRAC_BITS(FRAC_BITS), .CW(32 + UW), .SW(SWU)) u_norm_u (
    .clk_i, .rst_ni, .en_i(en),
    .ctl_i(ctl_c1), .comp_i(c1_w), .side_i(side_c1o),
    .ctl_o(ctl_u), .unit_o(u_w), .side_o(side_u)
  );

  // n x u
  logic signed [UW-1:0]   n_u [3];
  logic [SWV-1:0]         side_c2;
  lav_pkg::ctl_t          ctl_c2;
  logic signed [2*UW-1:0] c2_w [3];
  logic [SWV-1:0]         side_c2o;

  always_comb begin
    side_c2[SWV-1 -: SWU] = side_u;
    for (int i = 0; i < 3; i++) begin
      n_u[i] = $signed(side_u[3*UW-1-UW*i -: UW]);
      side_c2[3*UW-1-UW*i -: UW] = u_w[i];
    end
  end

  lav_cross #(.AW(UW), .BW(UW), .SW(SWV)) u_cross_v (
    .clk_i, .rst_ni, .en_i(en),
    .ctl_i(ctl_u), .a_i(n_u), .b_i(u_w), .side_i(side_c2),
    .ctl_o(ctl_c2), .c_o(c2_w), .side_o(side_c2o)
  );

  // v = normalize(n x u)
  lav_pkg::ctl_t        ctl_v;
  logic signed [UW-1:0] v_w [3];
  logic [SWV-1:0]       side_v;

  lav_norm #(.FRAC_BITS(FRAC_BITS), .CW(2 * UW), .SW(SWV)) u_norm_v (
    .clk_i, .rst_ni, .en_i(en),
    .ctl_i(ctl_c2), .comp_i(c2_w), .side_i(side_c2o),
    .ctl_o(ctl_v), .unit_o(v_w), .side_o(side_v)
  );

  // Translation, saturation and row-by-row output.
  logic signed [31:0]   eye_f [3];
  logic signed [UW-1:0] n_f   [3];
  logic signed [UW-1:0] u_f   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye_f[i] = $signed(side_v[SWV-1-32*i -: 32]);
      n_f[i]   = $signed(side_v[6*UW-1-UW*i -: UW]);
      u_f[i]   = $signed(side_v[3*UW-1-UW*i -: UW]);
    end
  end

  lav_out #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_out (
    .clk_i, .rst_ni,
    .ctl_i(ctl_v), .eye_i(eye_f), .u_i(u_f), .v_i(v_w), .n_i(n_f),
    .out_valid_o, .out_ready_i, .out_data_o,
    .en_o(en)
  );

endmodule
